// ----- rtl/lru_key_value_cache_assert.svh -----
// Assertion macros shared by the cache checker.
// No dependencies; include by bare file name.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication.
`define LKV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkv: same-cycle check failed");

// Next-cycle implication.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkv: next-cycle check failed");

// Implication after a fixed number of cycles.
`define LKV_ASSERT_AFTER(label, clk, rst, dly, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("lkv: delayed check failed");

`endif

// ----- rtl/lkv_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// No dependencies.
package lkv_pkg;

   localparam int FIELD_BITS = 32;
   localparam int CAP_BITS   = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic shift;
      logic update;
      logic valid;
   } lkv_cell_ctl_type;

endpackage

// ----- rtl/lkv_cell.sv -----
// One entry of the recency-ordered cell row: valid bit, key, value.
// Depends on lkv_pkg.
module lkv_cell #(
   parameter int KW = 32,
   parameter int VW = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lkv_pkg::lkv_cell_ctl_type ctl,
   input  logic [KW-1:0]             up_key,
   input  logic [VW-1:0]             up_value,
   input  logic [KW-1:0]             cmp_key,
   output logic [KW-1:0]             key,
   output logic [VW-1:0]             value,
   output logic                      match
);
   import lkv_pkg::*;

   logic          valid_ff, valid_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VW-1:0] value_ff, value_in;

   always_comb begin
      valid_in = ctl.update ? ctl.valid : valid_ff;
      key_in   = ctl.shift ? up_key : key_ff;
      value_in = ctl.shift ? up_value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign match = valid_ff && (key_ff == cmp_key);

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the LRU key/value cache: control and a row of lkv_cell entries.
// Depends on lkv_pkg and lkv_cell.
//
//  channel   ports                                   handshake
//  request   req_cmd, req_lookup_key, req_write_value  start && !busy
//  response  rsp_hit, rsp_read_value, rsp_evicted      rsp_strobe, one cycle
//  csr       csr_write_data (capacity)                 csr_write_enable
//
// Each beat runs through three steps: accept, compare across all cells (match
// registered), then the shift through the cell row. The response is shown in
// the cycle after the shift, when busy is already low again, so a new request
// can be taken while it is shown, but none while a beat is in flight. Reset
// (synchronous) clears every valid bit and the entry count; capacity returns to
// 16. The receiver cannot stall; nothing waits on it.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic signed [lkv_pkg::FIELD_BITS-1:0] req_lookup_key,
   input  logic signed [lkv_pkg::FIELD_BITS-1:0] req_write_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lkv_pkg::FIELD_BITS-1:0] rsp_read_value,
   output logic                                 rsp_evicted,
   input  logic                                 csr_write_enable,
   input  logic [lkv_pkg::CAP_BITS-1:0]          csr_write_data
);
   import lkv_pkg::*;

   localparam int KW   = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
   localparam int VW   = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_COMPARE, ST_UPDATE} state_type;

   state_type               state_ff, state_in;
   logic [CAP_BITS-1:0]     cap_ff, cap_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    cmd_ff, cmd_in;
   logic [KW-1:0]           key_ff, key_in;
   logic [VW-1:0]           val_ff, val_in;
   logic                    hit_ff, hit_in;
   logic [IW-1:0]           pos_ff, pos_in;
   logic [VW-1:0]           hitval_ff, hitval_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [FIELD_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                    rsp_evicted_ff, rsp_evicted_in;

   logic [KW-1:0]           cell_key   [MAX_ENTRIES];
   logic [VW-1:0]           cell_value [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  cell_match;
   lkv_cell_ctl_type        cell_ctl   [MAX_ENTRIES];

   logic                    match_any;
   logic [IW-1:0]           pos_or;
   logic [VW-1:0]           val_or;
   logic [CMPW-1:0]         cap_eff;
   logic [CMPW-1:0]         count_ext;
   logic [CMPW-1:0]         count_sum;
   logic                    upd;
   logic                    put_miss;
   logic                    moving;
   logic                    evict;
   logic [VW-1:0]           front_value;

   assign busy = (state_ff != ST_IDLE);

   // match reduction across the row
   always_comb begin
      match_any = 1'b0;
      pos_or    = '0;
      val_or    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_any = match_any | cell_match[i];
         pos_or    = pos_or | (cell_match[i] ? IW'(i) : '0);
         val_or    = val_or | (cell_match[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CMPW'(1);
      end else if (CMPW'(cap_ff) > CMPW'(MAX_ENTRIES)) begin
         cap_eff = CMPW'(MAX_ENTRIES);
      end else begin
         cap_eff = CMPW'(cap_ff);
      end
      count_ext = CMPW'(count_ff);
      upd       = (state_ff == ST_UPDATE);
      put_miss  = (cmd_ff == CMD_PUT) && !hit_ff;
      moving    = (cmd_ff == CMD_PUT) || hit_ff;
      if (cmd_ff == CMD_PUT) begin
         evict = hit_ff ? (count_ext > cap_eff) : (count_ext >= cap_eff);
      end else begin
         evict = 1'b0;
      end
      count_sum   = count_ext - CMPW'(evict) + CMPW'(put_miss);
      front_value = (cmd_ff == CMD_PUT) ? val_ff : hitval_ff;
   end

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctl[i].shift  = upd && moving && (put_miss || (IW'(i) <= pos_ff));
         cell_ctl[i].update = upd;
         cell_ctl[i].valid  = CW'(i) < count_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_write_enable ? csr_write_data : cap_ff;
      count_in       = count_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      hit_in         = hit_ff;
      pos_in         = pos_ff;
      hitval_in      = hitval_ff;
      rsp_strobe_in  = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               key_in   = req_lookup_key[KW-1:0];
               val_in   = req_write_value[VW-1:0];
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            hit_in    = match_any;
            pos_in    = pos_or;
            hitval_in = val_or;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            count_in       = count_sum[CW-1:0];
            rsp_strobe_in  = 1'b1;
            rsp_hit_in     = hit_ff;
            rsp_evicted_in = evict;
            if (cmd_ff == CMD_PUT) begin
               rsp_value_in = FIELD_BITS'(val_ff);
            end else if (hit_ff) begin
               rsp_value_in = FIELD_BITS'(hitval_ff);
            end else begin
               rsp_value_in = '1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      hit_ff         <= hit_in;
      pos_ff         <= pos_in;
      hitval_ff      <= hitval_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // cell 0 is most recent; each cell takes its upstream neighbor on shift
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [KW-1:0] up_key;
      logic [VW-1:0] up_value;
      if (g == 0) begin : g_head
         assign up_key   = key_ff;
         assign up_value = front_value;
      end else begin : g_body
         assign up_key   = cell_key[g-1];
         assign up_value = cell_value[g-1];
      end
      lkv_cell #(
         .KW (KW),
         .VW (VW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl[g]),
         .up_key   (up_key),
         .up_value (up_value),
         .cmp_key  (key_ff),
         .key      (cell_key[g]),
         .value    (cell_value[g]),
         .match    (cell_match[g])
      );
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule

// ----- rtl/lkv_checker.sv -----
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_assert.svh.
`include "lru_key_value_cache_assert.svh"

module lkv_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 req_cmd,
   input logic signed [lkv_pkg::FIELD_BITS-1:0] req_lookup_key,
   input logic signed [lkv_pkg::FIELD_BITS-1:0] req_write_value,
   input logic                                 rsp_strobe,
   input logic                                 rsp_hit,
   input logic signed [lkv_pkg::FIELD_BITS-1:0] rsp_read_value,
   input logic                                 rsp_evicted,
   input logic                                 csr_write_enable,
   input logic [lkv_pkg::CAP_BITS-1:0]          csr_write_data
);
   import lkv_pkg::*;

   logic accept;
   logic get_accept;
   logic idle_inputs;

   assign accept      = start && !busy;
   assign get_accept  = accept && (req_cmd == CMD_GET);
   assign idle_inputs = (^req_lookup_key === 1'bx) || (^req_write_value === 1'bx) ||
                        (csr_write_enable && (^csr_write_data === 1'bx));

   // busy right after a beat is taken
   `LKV_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy)
   // one response cycle per beat
   `LKV_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `LKV_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `LKV_ASSERT_AFTER(a_rsp_latency, clock, reset, 3, accept, rsp_strobe)
   // a get never evicts; a miss reads all ones
   `LKV_ASSERT_AFTER(a_get_result, clock, reset, 3, get_accept && !idle_inputs,
      !rsp_evicted && (rsp_hit || (rsp_read_value == '1)))

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_cmd          (req_cmd),
   .req_lookup_key   (req_lookup_key),
   .req_write_value  (req_write_value),
   .rsp_strobe       (rsp_strobe),
   .rsp_hit          (rsp_hit),
   .rsp_read_value   (rsp_read_value),
   .rsp_evicted      (rsp_evicted),
   .csr_write_enable (csr_write_enable),
   .csr_write_data   (csr_write_data)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for lru_key_value_cache: directed and random get/put traffic,
// predicted by an in-bench LRU store model and checked beat by beat.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 100ps

module testbench;
   import lkv_pkg::*;

   localparam int NUM_SLOTS      = 16;
   localparam int STALL_LIMIT    = 500;
   localparam int SETTLE_CYCLES  = 6;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_BEATS    = 152;

   typedef struct packed {
      logic                         hit;
      logic signed [FIELD_BITS-1:0] value;
      logic                         evicted;
   } lookup_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_cmd = CMD_GET;
   logic signed [FIELD_BITS-1:0] req_lookup_key = '0;
   logic signed [FIELD_BITS-1:0] req_write_value = '0;
   logic                         rsp_strobe;
   logic                         rsp_hit;
   logic signed [FIELD_BITS-1:0] rsp_read_value;
   logic                         rsp_evicted;
   logic                         csr_write_enable = 1'b0;
   logic [CAP_BITS-1:0]          csr_write_data = '0;

   // store model
   logic [CAP_BITS-1:0]   capacity_cfg = CAP_RESET;
   logic                  slot_used [NUM_SLOTS] = '{default: 1'b0};
   logic [FIELD_BITS-1:0] slot_key  [NUM_SLOTS] = '{default: '0};
   logic [FIELD_BITS-1:0] slot_data [NUM_SLOTS] = '{default: '0};
   int                    slot_age  [NUM_SLOTS] = '{default: 0};
   int                    used_count = 0;

   lookup_result_type     pending_results [$];
   logic [FIELD_BITS-1:0] key_pool [$];
   int                    error_count = 0;
   int                    stall_cycles = 0;

   lru_key_value_cache u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void make_newest(int s, int old_age);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_used[i] && i != s && slot_age[i] < old_age)
            slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   function automatic void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
            victim = i;
      end
      if (victim >= 0) begin
         slot_used[victim] = 1'b0;
         if (used_count > 0)
            used_count--;
      end
   endfunction

   function automatic lookup_result_type predict_lookup(logic cmd, logic [FIELD_BITS-1:0] key,
                                                        logic [FIELD_BITS-1:0] wval);
      lookup_result_type r;
      int                limit;
      int                s;
      limit = (capacity_cfg == 0) ? 1 :
              (capacity_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(capacity_cfg);
      s = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (s < 0 && slot_used[i] && slot_key[i] == key)
            s = i;
      end
      r.hit     = 1'b0;
      r.evicted = 1'b0;
      if (cmd == CMD_GET) begin
         if (s >= 0) begin
            r.hit   = 1'b1;
            r.value = slot_data[s];
            make_newest(s, slot_age[s]);
         end else begin
            r.value = '1;
         end
      end else begin
         r.value = wval;
         if (s >= 0) begin
            r.hit        = 1'b1;
            slot_data[s] = wval;
            make_newest(s, slot_age[s]);
            if (used_count > limit) begin
               drop_oldest();
               r.evicted = 1'b1;
            end
         end else begin
            if (used_count >= limit) begin
               drop_oldest();
               r.evicted = 1'b1;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (s < 0 && !slot_used[i])
                  s = i;
            end
            if (s >= 0) begin
               slot_used[s] = 1'b1;
               slot_key[s]  = key;
               slot_data[s] = wval;
               make_newest(s, NUM_SLOTS);
               used_count++;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Checker: one response beat per strobe, against the oldest prediction.
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $error("unexpected response beat: hit %b value %h evicted %b",
                   rsp_hit, rsp_read_value, rsp_evicted);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_hit !== exp_r.hit) begin
               error_count++;
               $error("hit: expected %b, got %b", exp_r.hit, rsp_hit);
            end
            if (rsp_read_value !== exp_r.value) begin
               error_count++;
               $error("read_value: expected %h, got %h", exp_r.value, rsp_read_value);
            end
            if (rsp_evicted !== exp_r.evicted) begin
               error_count++;
               $error("evicted: expected %b, got %b", exp_r.evicted, rsp_evicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_beat(input logic cmd, input logic [FIELD_BITS-1:0] key,
                            input logic [FIELD_BITS-1:0] wval);
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_lookup_key  <= key;
      req_write_value <= wval;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_lookup(cmd, key, wval));
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      capacity_cfg = cap;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_directed_access();
      send_beat(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_beat(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_beat(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(CMD_GET, 32'h8000_0000, 32'h5555_5555);
      send_beat(CMD_PUT, 32'h7fff_ffff, 32'h1234_5678);
      send_beat(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
      send_beat(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
      send_beat(CMD_GET, 32'h0000_0001, 32'haaaa_aaaa);
   endtask

   task automatic test_directed_capacity();
      // shrink below the entries in use: gets leave it over, puts trim it
      write_capacity(5'd2);
      send_beat(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_beat(CMD_PUT, 32'h0000_0000, 32'h0000_0005);
      send_beat(CMD_PUT, 32'hffff_ffff, 32'h0000_0007);
      send_beat(CMD_PUT, 32'h5a5a_5a5a, 32'h0000_0001);
      send_beat(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      write_capacity(5'd0);
      send_beat(CMD_PUT, 32'h0f0f_0f0f, 32'h0000_0002);
      send_beat(CMD_GET, 32'h5a5a_5a5a, 32'h0000_0000);
      send_beat(CMD_GET, 32'h0f0f_0f0f, 32'h0000_0000);
      write_capacity(5'd31);
      send_beat(CMD_PUT, 32'h1111_1111, 32'hdead_beef);
      send_beat(CMD_PUT, 32'h2222_2222, 32'h8000_0000);
      send_beat(CMD_GET, 32'h0f0f_0f0f, 32'h0000_0000);
      send_beat(CMD_GET, 32'h1111_1111, 32'h0000_0000);
      send_beat(CMD_PUT, 32'h0f0f_0f0f, 32'h7fff_ffff);
   endtask

   task automatic test_random_traffic();
      logic [CAP_BITS-1:0] cap_plan [RANDOM_PHASES];
      logic                idle_on;
      int                  pool_len;
      logic [FIELD_BITS-1:0] key;
      cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd8, 5'd3,
                   5'd0, 5'd1, 5'd16};
      cap_plan[9] = CAP_BITS'($urandom_range(0, 31));
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_capacity(cap_plan[p]);
         idle_on  = (p != RANDOM_PHASES - 1) && (p % 4 != 3);
         pool_len = ((cap_plan[p] == 0) ? 1 : (cap_plan[p] > NUM_SLOTS) ? NUM_SLOTS :
                     int'(cap_plan[p])) + $urandom_range(1, 4);
         key_pool.delete();
         for (int k = 0; k < pool_len; k++)
            key_pool.push_back(($urandom_range(0, 7) == 0) ? rand_word() : $urandom);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 99) < 85)
               key = key_pool[$urandom_range(0, pool_len - 1)];
            else
               key = rand_word();
            send_beat(logic'($urandom_range(0, 1)), key, rand_word());
            if (idle_on && $urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 5));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_access();
      test_directed_capacity();
      test_random_traffic();
      drain_results();
      if (pending_results.size() != 0)
         error_count++;
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
tb/sv/testbench.sv
